/* src/i2cm_pkg.sv */
// shared types and constants of the i2c master byte engine
`default_nettype none
package i2cm_pkg;

	// configuration registers
	localparam int unsigned NUM_REGS  = 7;
	localparam int unsigned CFG_W     = 10;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SETUP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_SETUP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_FREE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH    = 3'd6;

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_t;

	localparam cfg_t CFG_RESET = {10'd256, 10'd20, 10'd3, 10'd6, 10'd0, 10'd0, 10'd2};

	// phase codes
	localparam int unsigned PH_W = 3;
	localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PH_W-1:0] PH_SETUP  = 3'd1;
	localparam logic [PH_W-1:0] PH_WAIT   = 3'd2;
	localparam logic [PH_W-1:0] PH_HIGH   = 3'd3;
	localparam logic [PH_W-1:0] PH_LOW    = 3'd4;
	localparam logic [PH_W-1:0] PH_HOLD   = 3'd5;
	localparam logic [PH_W-1:0] PH_STOPSU = 3'd6;
	localparam logic [PH_W-1:0] PH_FREE   = 3'd7;

	// command codes
	localparam logic [1:0] M_START = 2'd0;
	localparam logic [1:0] M_STOP  = 2'd1;
	localparam logic [1:0] M_WRITE = 2'd2;
	localparam logic [1:0] M_READ  = 2'd3;

	// bits per byte, the ack bit has this index
	localparam logic [3:0] LAST_BIT = 4'd8;

	// one tick of bus samples and command
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       scl_in;
		logic       sda_in;
	} item_t;

	// line drives and status after one tick
	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       ready_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       timed_out;
	} result_t;

endpackage
`default_nettype wire

/* src/i2cm_step.sv */
// next-state and result logic for one bus tick
`default_nettype none
module i2cm_step #(
	parameter int unsigned TIMER_WIDTH      = 10,
	parameter int unsigned FAIL_COUNT_WIDTH = 16
) (
	input  var i2cm_pkg::item_t                  item,
	input  var i2cm_pkg::cfg_t                   cfg,
	input  wire logic [i2cm_pkg::PH_W-1:0]       phase,
	input  wire logic [3:0]                      bit_index,
	input  wire logic [7:0]                      shift_reg,
	input  wire logic [TIMER_WIDTH-1:0]          delay_timer,
	input  wire logic [TIMER_WIDTH-1:0]          stretch_timer,
	input  wire logic [FAIL_COUNT_WIDTH-1:0]     fail_cnt,
	input  wire logic                            scl_drive,
	input  wire logic                            sda_drive,
	input  wire logic [1:0]                      active_mode,
	input  wire logic                            ack_bit,
	output logic [i2cm_pkg::PH_W-1:0]            phase_nxt,
	output logic [3:0]                           bit_index_nxt,
	output logic [7:0]                           shift_reg_nxt,
	output logic [TIMER_WIDTH-1:0]               delay_timer_nxt,
	output logic [TIMER_WIDTH-1:0]               stretch_timer_nxt,
	output logic [FAIL_COUNT_WIDTH-1:0]          fail_cnt_nxt,
	output logic                                 scl_drive_nxt,
	output logic                                 sda_drive_nxt,
	output logic [1:0]                           active_mode_nxt,
	output logic                                 ack_bit_nxt,
	output i2cm_pkg::result_t                    res
);

	// registers cut to timer width
	logic [TIMER_WIDTH-1:0] reg_m [i2cm_pkg::NUM_REGS];

	for (genvar i = 0; i < i2cm_pkg::NUM_REGS; i++) begin : g_mask
		assign reg_m[i] = TIMER_WIDTH'({{TIMER_WIDTH{1'b0}}, cfg[i]});
	end

	// delay register that belongs to the current phase
	logic [TIMER_WIDTH-1:0] dly_lim;
	logic                   dly_hit;

	always_comb begin
		unique case (phase)
			i2cm_pkg::PH_SETUP:  dly_lim = reg_m[i2cm_pkg::REG_SETUP];
			i2cm_pkg::PH_HIGH:   dly_lim = reg_m[i2cm_pkg::REG_HIGH];
			i2cm_pkg::PH_LOW:    dly_lim = reg_m[i2cm_pkg::REG_LOW];
			i2cm_pkg::PH_HOLD:   dly_lim = reg_m[i2cm_pkg::REG_HOLD_START];
			i2cm_pkg::PH_STOPSU: dly_lim = reg_m[i2cm_pkg::REG_STOP_SETUP];
			i2cm_pkg::PH_FREE:   dly_lim = reg_m[i2cm_pkg::REG_BUS_FREE];
			default:             dly_lim = '0;
		endcase
	end

	assign dly_hit = (delay_timer >= dly_lim);

	// clock stretch timer, saturating, with a limit of zero taken as one
	logic [TIMER_WIDTH-1:0] st_inc;
	logic [TIMER_WIDTH-1:0] st_lim;
	logic                   scl_high;
	logic                   st_timeout;

	assign st_inc     = (stretch_timer != '1) ? stretch_timer + 1'b1 : stretch_timer;
	assign st_lim     = (reg_m[i2cm_pkg::REG_STRETCH] == '0) ? TIMER_WIDTH'(1)
	                                                         : reg_m[i2cm_pkg::REG_STRETCH];
	assign scl_high   = item.scl_in;
	assign st_timeout = !scl_high && (st_inc >= st_lim);

	// next bit position and shifted write data for the low phase
	logic [3:0] bi_inc;
	logic [7:0] sh_left;

	assign bi_inc  = bit_index + 4'd1;
	assign sh_left = {shift_reg[6:0], 1'b0};

	// phase sequencer
	always_comb begin
		phase_nxt         = phase;
		bit_index_nxt     = bit_index;
		shift_reg_nxt     = shift_reg;
		delay_timer_nxt   = delay_timer;
		stretch_timer_nxt = stretch_timer;
		fail_cnt_nxt      = fail_cnt;
		scl_drive_nxt     = scl_drive;
		sda_drive_nxt     = sda_drive;
		active_mode_nxt   = active_mode;
		ack_bit_nxt       = ack_bit;
		res.done_res      = 1'b0;
		res.rx_byte       = '0;
		res.ack_seen      = 1'b0;
		res.timed_out     = 1'b0;

		unique case (phase)
			i2cm_pkg::PH_IDLE: begin
				if (item.cmd_valid) begin
					active_mode_nxt   = item.mode;
					bit_index_nxt     = '0;
					stretch_timer_nxt = '0;
					unique case (item.mode)
						i2cm_pkg::M_START: sda_drive_nxt = 1'b0;
						i2cm_pkg::M_STOP:  sda_drive_nxt = 1'b1;
						i2cm_pkg::M_WRITE: begin
							shift_reg_nxt = item.tx_byte;
							sda_drive_nxt = !item.tx_byte[7];
						end
						default: begin
							shift_reg_nxt = '0;
							ack_bit_nxt   = item.ack_to_send;
							sda_drive_nxt = 1'b0;
						end
					endcase
					phase_nxt       = i2cm_pkg::PH_SETUP;
					delay_timer_nxt = '0;
				end
			end

			i2cm_pkg::PH_SETUP: begin
				if (dly_hit) begin
					scl_drive_nxt     = 1'b0;
					stretch_timer_nxt = '0;
					phase_nxt         = i2cm_pkg::PH_WAIT;
					delay_timer_nxt   = '0;
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end

			i2cm_pkg::PH_WAIT: begin
				if (!scl_high) begin
					stretch_timer_nxt = st_inc;
				end
				priority if (active_mode == i2cm_pkg::M_START) begin
					if (scl_high || st_timeout) begin
						sda_drive_nxt   = 1'b1;
						phase_nxt       = i2cm_pkg::PH_HOLD;
						delay_timer_nxt = '0;
					end
				end else if (active_mode == i2cm_pkg::M_STOP) begin
					if (scl_high || st_timeout) begin
						phase_nxt       = i2cm_pkg::PH_STOPSU;
						delay_timer_nxt = '0;
					end
				end else if (scl_high) begin
					// sample data bit on a read, the slave's ack on a write
					if (bit_index < i2cm_pkg::LAST_BIT) begin
						if (active_mode == i2cm_pkg::M_READ) begin
							shift_reg_nxt = {shift_reg[6:0], item.sda_in};
						end
					end else if (active_mode == i2cm_pkg::M_WRITE) begin
						ack_bit_nxt = item.sda_in;
					end
					phase_nxt       = i2cm_pkg::PH_HIGH;
					delay_timer_nxt = '0;
				end else if (st_timeout) begin
					// byte command aborts on stretch timeout
					res.done_res  = 1'b1;
					res.timed_out = 1'b1;
					res.ack_seen  = 1'b1;
					if (fail_cnt != '1) begin
						fail_cnt_nxt = fail_cnt + 1'b1;
					end
					phase_nxt = i2cm_pkg::PH_IDLE;
				end
			end

			i2cm_pkg::PH_HIGH: begin
				if (dly_hit) begin
					scl_drive_nxt = 1'b1;
					if (bit_index >= i2cm_pkg::LAST_BIT) begin
						res.done_res = 1'b1;
						if (active_mode == i2cm_pkg::M_WRITE) begin
							res.ack_seen = ack_bit;
						end else begin
							res.rx_byte = shift_reg;
						end
						phase_nxt = i2cm_pkg::PH_IDLE;
					end else begin
						phase_nxt       = i2cm_pkg::PH_LOW;
						delay_timer_nxt = '0;
					end
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end

			i2cm_pkg::PH_LOW: begin
				if (dly_hit) begin
					bit_index_nxt = bi_inc;
					if (active_mode == i2cm_pkg::M_WRITE) begin
						shift_reg_nxt = sh_left;
						sda_drive_nxt = (bi_inc < i2cm_pkg::LAST_BIT) ? !sh_left[7] : 1'b0;
					end else begin
						sda_drive_nxt = (bi_inc < i2cm_pkg::LAST_BIT) ? 1'b0 : !ack_bit;
					end
					phase_nxt       = i2cm_pkg::PH_SETUP;
					delay_timer_nxt = '0;
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end

			i2cm_pkg::PH_HOLD: begin
				if (dly_hit) begin
					scl_drive_nxt = 1'b1;
					res.done_res  = 1'b1;
					phase_nxt     = i2cm_pkg::PH_IDLE;
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end

			i2cm_pkg::PH_STOPSU: begin
				if (dly_hit) begin
					sda_drive_nxt   = 1'b0;
					phase_nxt       = i2cm_pkg::PH_FREE;
					delay_timer_nxt = '0;
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end

			default: begin
				// bus free time after a stop
				if (dly_hit) begin
					res.done_res = 1'b1;
					phase_nxt    = i2cm_pkg::PH_IDLE;
				end else begin
					delay_timer_nxt = delay_timer + 1'b1;
				end
			end
		endcase

		res.scl_low   = scl_drive_nxt;
		res.sda_low   = sda_drive_nxt;
		res.ready_res = (phase_nxt == i2cm_pkg::PH_IDLE);
	end

endmodule
`default_nettype wire

/* src/i2c_master_byte_engine.sv */
// top level of the i2c master byte engine
// One request is one bus tick: the sampled SCL and SDA levels and an optional command
// (start, stop, write byte, read byte). Each accepted tick yields exactly one result with
// the line drives, ready, done and the byte, ack and timeout status after that tick.
// A tick is registered on entry, the phase sequencer evaluates it combinationally and the
// result sits in an output register; throughput is one tick per cycle while results are taken.
// Configuration writes take effect at once; the user must make them only while the engine
// is idle, and the engine itself does not enforce this.
`default_nettype none
module i2c_master_byte_engine #(
	parameter int unsigned TIMER_WIDTH      = 10,
	parameter int unsigned FAIL_COUNT_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [i2cm_pkg::CFG_W-1:0]     cfg_data,
	// tick requests
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cmd_valid,
	input  wire logic [1:0]                     mode,
	input  wire logic [7:0]                     tx_byte,
	input  wire logic                           ack_to_send,
	input  wire logic                           scl_in,
	input  wire logic                           sda_in,
	// results
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                scl_low,
	output logic                                sda_low,
	output logic                                ready_res,
	output logic                                done_res,
	output logic [7:0]                          rx_byte,
	output logic                                ack_seen,
	output logic                                timed_out,
	output logic [15:0]                         fail_count
);

	// configuration registers
	i2cm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= i2cm_pkg::CFG_RESET;
		end else if (cfg_we && (cfg_index < i2cm_pkg::CFG_IDX_W'(i2cm_pkg::NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline control
	logic              vld_s1;
	logic              vld_s2;
	logic              adv;
	i2cm_pkg::item_t   item_s1;
	i2cm_pkg::result_t res_s2;
	logic [15:0]       fail_s2;

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd_valid: cmd_valid, mode: mode, tx_byte: tx_byte,
			             ack_to_send: ack_to_send, scl_in: scl_in, sda_in: sda_in};
		end
	end

	// engine state
	logic [i2cm_pkg::PH_W-1:0]   phase_q,         phase_nxt;
	logic [3:0]                  bit_index_q,     bit_index_nxt;
	logic [7:0]                  shift_reg_q,     shift_reg_nxt;
	logic [TIMER_WIDTH-1:0]      delay_timer_q,   delay_timer_nxt;
	logic [TIMER_WIDTH-1:0]      stretch_timer_q, stretch_timer_nxt;
	logic [FAIL_COUNT_WIDTH-1:0] fail_cnt_q,      fail_cnt_nxt;
	logic                        scl_drive_q,     scl_drive_nxt;
	logic                        sda_drive_q,     sda_drive_nxt;
	logic [1:0]                  active_mode_q,   active_mode_nxt;
	logic                        ack_bit_q,       ack_bit_nxt;
	i2cm_pkg::result_t           res;

	i2cm_step #(
		.TIMER_WIDTH      (TIMER_WIDTH),
		.FAIL_COUNT_WIDTH (FAIL_COUNT_WIDTH)
	) u_step (
		.item              (item_s1),
		.cfg               (cfg_q),
		.phase             (phase_q),
		.bit_index         (bit_index_q),
		.shift_reg         (shift_reg_q),
		.delay_timer       (delay_timer_q),
		.stretch_timer     (stretch_timer_q),
		.fail_cnt          (fail_cnt_q),
		.scl_drive         (scl_drive_q),
		.sda_drive         (sda_drive_q),
		.active_mode       (active_mode_q),
		.ack_bit           (ack_bit_q),
		.phase_nxt         (phase_nxt),
		.bit_index_nxt     (bit_index_nxt),
		.shift_reg_nxt     (shift_reg_nxt),
		.delay_timer_nxt   (delay_timer_nxt),
		.stretch_timer_nxt (stretch_timer_nxt),
		.fail_cnt_nxt      (fail_cnt_nxt),
		.scl_drive_nxt     (scl_drive_nxt),
		.sda_drive_nxt     (sda_drive_nxt),
		.active_mode_nxt   (active_mode_nxt),
		.ack_bit_nxt       (ack_bit_nxt),
		.res               (res)
	);

	// state moves on when a tick leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= i2cm_pkg::PH_IDLE;
			bit_index_q     <= '0;
			shift_reg_q     <= '0;
			delay_timer_q   <= '0;
			stretch_timer_q <= '0;
			fail_cnt_q      <= '0;
			scl_drive_q     <= 1'b0;
			sda_drive_q     <= 1'b0;
			active_mode_q   <= i2cm_pkg::M_START;
			ack_bit_q       <= 1'b0;
		end else if (adv) begin
			phase_q         <= phase_nxt;
			bit_index_q     <= bit_index_nxt;
			shift_reg_q     <= shift_reg_nxt;
			delay_timer_q   <= delay_timer_nxt;
			stretch_timer_q <= stretch_timer_nxt;
			fail_cnt_q      <= fail_cnt_nxt;
			scl_drive_q     <= scl_drive_nxt;
			sda_drive_q     <= sda_drive_nxt;
			active_mode_q   <= active_mode_nxt;
			ack_bit_q       <= ack_bit_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2  <= res;
			fail_s2 <= 16'({16'b0, fail_cnt_nxt});
		end
	end

	assign out_valid  = vld_s2;
	assign scl_low    = res_s2.scl_low;
	assign sda_low    = res_s2.sda_low;
	assign ready_res  = res_s2.ready_res;
	assign done_res   = res_s2.done_res;
	assign rx_byte    = res_s2.rx_byte;
	assign ack_seen   = res_s2.ack_seen;
	assign timed_out  = res_s2.timed_out;
	assign fail_count = fail_s2;

endmodule
`default_nettype wire

/* src/i2cm_checker.sv */
// port-level checks of the i2c master byte engine and their binding
`default_nettype none
module i2cm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       ready_res,
	input wire logic       done_res,
	input wire logic [7:0] rx_byte,
	input wire logic       ack_seen,
	input wire logic       timed_out
);

	// a finished command always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> ready_res)
		else $error("command finished without returning to idle");

	// an abort reports a finished command with nack and no data
	a_timeout_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> done_res && ack_seen && (rx_byte == 8'd0))
		else $error("timeout reported with wrong status");

	// read data only comes with a finished read, which carries no nack
	a_rx_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rx_byte != 8'd0) |-> done_res && !ack_seen && !timed_out)
		else $error("read data outside a finished read");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(done_res))
		else $error("result changed while stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ready_res (ready_res),
	.done_res  (done_res),
	.rx_byte   (rx_byte),
	.ack_seen  (ack_seen),
	.timed_out (timed_out)
);
`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the i2c master byte engine: table of bus ticks, then random traffic
module tb_top;
	import i2cm_pkg::*;

	localparam int MAX_CYCLES = 1000000;
	localparam int NUM_DIR    = 23;

	// expected line drives and status after one tick
	typedef struct packed {
		result_t     res;
		logic [15:0] fails;
	} tick_status_t;

	// one row of the directed table: a register write or a bus tick
	typedef struct packed {
		logic                 cfg_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		item_t                tick;
		logic                 typed;
		tick_status_t         want;
	} dir_row_t;

	localparam tick_status_t NO_WANT = '0;
	localparam item_t        NO_TICK = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd_valid = 1'b0;
	logic [1:0]           mode = M_START;
	logic [7:0]           tx_byte = '0;
	logic                 ack_to_send = 1'b0;
	logic                 scl_in = 1'b1;
	logic                 sda_in = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 scl_low;
	logic                 sda_low;
	logic                 ready_res;
	logic                 done_res;
	logic [7:0]           rx_byte;
	logic                 ack_seen;
	logic                 timed_out;
	logic [15:0]          fail_count;

	i2c_master_byte_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd_valid(cmd_valid), .mode(mode), .tx_byte(tx_byte),
		.ack_to_send(ack_to_send), .scl_in(scl_in), .sda_in(sda_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_low(scl_low), .sda_low(sda_low), .ready_res(ready_res),
		.done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen),
		.timed_out(timed_out), .fail_count(fail_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// directed ticks: zero delays and zero stretch limit, so every byte times out at once
	dir_row_t directed_rows [NUM_DIR] = '{
		'{1'b0, '0, '0, '{1'b0, M_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{'{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}, 16'd0}},
		'{1'b1, REG_SETUP,      10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_HIGH,       10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_LOW,        10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_HOLD_START, 10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_STOP_SETUP, 10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_BUS_FREE,   10'd0, NO_TICK, 1'b0, NO_WANT},
		'{1'b1, REG_STRETCH,    10'd0, NO_TICK, 1'b0, NO_WANT},
		// write of all zeros, a command while busy, then a stretched clock
		'{1'b0, '0, '0, '{1'b1, M_WRITE, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b1, M_READ,  8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{'{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1}, 16'd1}},
		// read that times out
		'{1'b0, '0, '0, '{1'b1, M_READ,  8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b1,
			'{'{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1}, 16'd2}},
		// start goes on through a timeout
		'{1'b0, '0, '0, '{1'b1, M_START, 8'hFF, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{'{1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0}, 16'd2}},
		// stop with the clock high at once
		'{1'b0, '0, '0, '{1'b1, M_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, '0, '0, '{1'b0, M_STOP,  8'h00, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{'{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0}, 16'd2}}
	};

	// engine state as predicted
	logic [CFG_W-1:0] cfg_shadow [NUM_REGS];
	logic [PH_W-1:0]  eng_phase = PH_IDLE;
	logic [3:0]       bit_cnt = '0;
	logic [7:0]       shifter = '0;
	logic [CFG_W-1:0] delay_cnt = '0;
	logic [CFG_W-1:0] stretch_cnt = '0;
	logic [15:0]      fail_tally = '0;
	logic             scl_pull = 1'b0;
	logic             sda_pull = 1'b0;
	logic [1:0]       eng_mode = M_START;
	logic             ack_latch = 1'b0;

	tick_status_t pending_status [$];
	tick_status_t got_status;
	int           bad_count = 0;
	int           cycle_count = 0;
	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;

	// stimulus shaping: position in a start/bytes/stop transaction and a clock stretch
	int   seq_pos = 0;
	int   seq_bytes = 1;
	logic rd_dir = 1'b0;
	int   hold_low = 0;

	function automatic bit delay_elapsed(input logic [CFG_IDX_W-1:0] idx);
		if (delay_cnt >= cfg_shadow[idx])
			return 1'b1;
		delay_cnt = delay_cnt + 1'b1;
		return 1'b0;
	endfunction

	function automatic void enter_phase(input logic [PH_W-1:0] ph);
		eng_phase = ph;
		delay_cnt = '0;
	endfunction

	// one bus tick through the phase sequencer
	function automatic tick_status_t advance_engine(input item_t t);
		tick_status_t     r;
		logic [CFG_W-1:0] lim;
		logic             stretch_out;
		r = '0;
		stretch_out = 1'b0;
		case (eng_phase)
			PH_IDLE: begin
				if (t.cmd_valid) begin
					eng_mode = t.mode;
					bit_cnt = '0;
					stretch_cnt = '0;
					case (t.mode)
						M_START: sda_pull = 1'b0;
						M_STOP:  sda_pull = 1'b1;
						M_WRITE: begin
							shifter = t.tx_byte;
							sda_pull = ~t.tx_byte[7];
						end
						default: begin
							shifter = '0;
							ack_latch = t.ack_to_send;
							sda_pull = 1'b0;
						end
					endcase
					enter_phase(PH_SETUP);
				end
			end
			PH_SETUP: begin
				if (delay_elapsed(REG_SETUP)) begin
					scl_pull = 1'b0;
					stretch_cnt = '0;
					enter_phase(PH_WAIT);
				end
			end
			PH_WAIT: begin
				// clock stretching: count ticks with scl still low
				if (!t.scl_in) begin
					lim = cfg_shadow[REG_STRETCH];
					if (lim == '0)
						lim = 10'd1;
					if (stretch_cnt != '1)
						stretch_cnt = stretch_cnt + 1'b1;
					stretch_out = (stretch_cnt >= lim);
				end
				if (eng_mode == M_START) begin
					if (t.scl_in || stretch_out) begin
						sda_pull = 1'b1;
						enter_phase(PH_HOLD);
					end
				end else if (eng_mode == M_STOP) begin
					if (t.scl_in || stretch_out)
						enter_phase(PH_STOPSU);
				end else if (t.scl_in) begin
					if (bit_cnt < LAST_BIT) begin
						if (eng_mode == M_READ)
							shifter = {shifter[6:0], t.sda_in};
					end else if (eng_mode == M_WRITE) begin
						ack_latch = t.sda_in;
					end
					enter_phase(PH_HIGH);
				end else if (stretch_out) begin
					r.res.done_res = 1'b1;
					r.res.timed_out = 1'b1;
					r.res.ack_seen = 1'b1;
					if (fail_tally != '1)
						fail_tally = fail_tally + 1'b1;
					eng_phase = PH_IDLE;
				end
			end
			PH_HIGH: begin
				if (delay_elapsed(REG_HIGH)) begin
					scl_pull = 1'b1;
					if (bit_cnt >= LAST_BIT) begin
						r.res.done_res = 1'b1;
						if (eng_mode == M_WRITE)
							r.res.ack_seen = ack_latch;
						else
							r.res.rx_byte = shifter;
						eng_phase = PH_IDLE;
					end else begin
						enter_phase(PH_LOW);
					end
				end
			end
			PH_LOW: begin
				if (delay_elapsed(REG_LOW)) begin
					bit_cnt = bit_cnt + 1'b1;
					if (eng_mode == M_WRITE) begin
						shifter = {shifter[6:0], 1'b0};
						sda_pull = (bit_cnt < LAST_BIT) ? ~shifter[7] : 1'b0;
					end else begin
						sda_pull = (bit_cnt < LAST_BIT) ? 1'b0 : ~ack_latch;
					end
					enter_phase(PH_SETUP);
				end
			end
			PH_HOLD: begin
				if (delay_elapsed(REG_HOLD_START)) begin
					scl_pull = 1'b1;
					r.res.done_res = 1'b1;
					eng_phase = PH_IDLE;
				end
			end
			PH_STOPSU: begin
				if (delay_elapsed(REG_STOP_SETUP)) begin
					sda_pull = 1'b0;
					enter_phase(PH_FREE);
				end
			end
			PH_FREE: begin
				if (delay_elapsed(REG_BUS_FREE)) begin
					r.res.done_res = 1'b1;
					eng_phase = PH_IDLE;
				end
			end
			default: eng_phase = PH_IDLE;
		endcase
		r.res.scl_low = scl_pull;
		r.res.sda_low = sda_pull;
		r.res.ready_res = (eng_phase == PH_IDLE);
		r.fails = fail_tally;
		return r;
	endfunction

	// slave clock stretch for the next high phase, sometimes right at the limit
	function automatic int pick_stretch();
		int r;
		int lim;
		lim = int'(cfg_shadow[REG_STRETCH]);
		if (lim == 0)
			lim = 1;
		r = $urandom_range(0, 99);
		if (r < 78)
			return 0;
		if (r < 97)
			return $urandom_range(1, 4);
		return $urandom_range(lim - 1, lim + 1);
	endfunction

	// next bus tick: mostly well-formed transactions, some noise and busy commands
	function automatic item_t pick_bus_tick();
		item_t t;
		int    r;
		t.tx_byte = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 9);
		if (r == 0)
			t.tx_byte = 8'h00;
		else if (r == 1)
			t.tx_byte = 8'hFF;
		t.ack_to_send = 1'($urandom_range(0, 1));
		t.mode = 2'($urandom_range(0, 3));
		t.sda_in = 1'($urandom_range(0, 1));
		t.cmd_valid = 1'b0;
		if (eng_phase == PH_IDLE) begin
			t.scl_in = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 99) < 75) begin
				t.cmd_valid = 1'b1;
				hold_low = pick_stretch();
				if ($urandom_range(0, 9) != 0) begin
					if (seq_pos == 0) begin
						t.mode = M_START;
						seq_bytes = $urandom_range(1, 3);
					end else if (seq_pos == 1) begin
						t.mode = M_WRITE;
						rd_dir = t.tx_byte[0];
					end else if (seq_pos <= seq_bytes + 1) begin
						t.mode = rd_dir ? M_READ : M_WRITE;
						t.ack_to_send = (seq_pos == seq_bytes + 1) ^ ($urandom_range(0, 9) == 0);
					end else begin
						t.mode = M_STOP;
					end
					seq_pos = (t.mode == M_STOP) ? 0 : seq_pos + 1;
				end
			end
		end else begin
			t.cmd_valid = ($urandom_range(0, 9) == 0);
			if (scl_pull) begin
				t.scl_in = ($urandom_range(0, 19) == 0);
				hold_low = pick_stretch();
			end else if (hold_low != 0) begin
				t.scl_in = 1'b0;
				hold_low--;
			end else begin
				t.scl_in = 1'b1;
			end
		end
		return t;
	endfunction

	// offer one tick request, wait for it to be taken, then predict its status
	task automatic send_tick(input item_t t, input bit typed, input tick_status_t want);
		tick_status_t predicted;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		{cmd_valid, mode, tx_byte, ack_to_send, scl_in, sda_in} <= t;
		do @(posedge clk); while (!(in_valid && in_ready));
		predicted = advance_engine(t);
		pending_status.push_back(typed ? want : predicted);
	endtask

	// finish any command with an undisturbed clock and let every status come back
	task automatic settle_engine();
		item_t t;
		while (eng_phase != PH_IDLE) begin
			t = '0;
			t.scl_in = 1'b1;
			t.sda_in = 1'($urandom_range(0, 1));
			t.tx_byte = 8'($urandom_range(0, 255));
			send_tick(t, 1'b0, NO_WANT);
		end
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_shadow[idx] = val;
	endtask

	// one setting of the timing registers with random traffic under one idling pattern
	task automatic run_phase(input logic [CFG_W-1:0] su, hi, lo, hs, ss, bf, lim,
			input int n_ticks, input int idle_pct, input int stall_pct);
		int    counted;
		bit    was_idle;
		item_t t;
		counted = 0;
		settle_engine();
		write_reg(REG_SETUP, su);
		write_reg(REG_HIGH, hi);
		write_reg(REG_LOW, lo);
		write_reg(REG_HOLD_START, hs);
		write_reg(REG_STOP_SETUP, ss);
		write_reg(REG_BUS_FREE, bf);
		write_reg(REG_STRETCH, lim);
		cfg_we <= 1'b0;
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		while (counted < n_ticks) begin
			t = pick_bus_tick();
			was_idle = (eng_phase == PH_IDLE);
			send_tick(t, 1'b0, NO_WANT);
			// ticks that leave an idle engine untouched are not counted
			if (!(was_idle && !t.cmd_valid))
				counted++;
		end
	endtask

	task automatic report_bad(input string why, input tick_status_t want, input tick_status_t got);
		bad_count++;
		if (bad_count <= 10)
			$display("%s: expected scl %0b sda %0b rdy %0b done %0b rx %02h ack %0b tmo %0b cnt %0d,",
				why, want.res.scl_low, want.res.sda_low, want.res.ready_res,
				want.res.done_res, want.res.rx_byte, want.res.ack_seen,
				want.res.timed_out, want.fails,
				" got scl %0b sda %0b rdy %0b done %0b rx %02h ack %0b tmo %0b cnt %0d",
				got.res.scl_low, got.res.sda_low,
				got.res.ready_res, got.res.done_res, got.res.rx_byte, got.res.ack_seen,
				got.res.timed_out, got.fails);
	endtask

	// result side: random stalls, compare each status with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_status = '{'{scl_low, sda_low, ready_res, done_res, rx_byte, ack_seen,
				timed_out}, fail_count};
			if (pending_status.size() == 0)
				report_bad("status with nothing pending", NO_WANT, got_status);
			else if (got_status !== pending_status[0])
				report_bad("status mismatch", pending_status.pop_front(), got_status);
			else
				void'(pending_status.pop_front());
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			cfg_shadow[i] = CFG_RESET[i];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < NUM_DIR; k++) begin
			if (directed_rows[k].cfg_write) begin
				settle_engine();
				write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
				cfg_we <= 1'b0;
			end else begin
				send_tick(directed_rows[k].tick, directed_rows[k].typed,
					directed_rows[k].want);
			end
		end

		// random traffic over several timing settings and idling patterns
		run_phase(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd3, 260, 0, 0);
		run_phase(10'd2, 10'd0, 10'd0, 10'd6, 10'd3, 10'd20, 10'd256, 200, 67, 0);
		run_phase(10'($urandom_range(0, 4)), 10'($urandom_range(0, 4)),
			10'($urandom_range(0, 4)), 10'($urandom_range(0, 4)),
			10'($urandom_range(0, 4)), 10'($urandom_range(0, 4)),
			10'($urandom_range(1, 24)), 250, 0, 67);
		// short delays with the widest stretch limit
		run_phase(10'd5, 10'd4, 10'd3, 10'd7, 10'd6, 10'd12, 10'd1023,
			40, 30, 30);
		run_phase(10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)),
			10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)),
			10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)),
			10'd1, 200, 0, 0);

		// drain
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_count == 0 && pending_status.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
